[rtl/pfxl_pkg.sv]
// shared types, codes and defaults for the padded frame exchange link
package pfxl_pkg;

    localparam int FRAME_BYTES_DEF  = 64;
    localparam int PAD_BYTES_DEF    = 4;
    localparam int ALIGN_WINDOW_DEF = 5;
    localparam int RX_BYTES_DEF     = 68;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE     = 2'd3;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [15:0] guard_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  pad_value;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_marker:  8'h00,
        guard_ticks:   16'd1200,
        timeout_ticks: 16'd10000,
        pad_value:     8'hF0
    };

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SLOT   = 3'd1,
        OP_RXBYTE = 3'd2,
        OP_TICK   = 3'd3,
        OP_TAKE   = 3'd4,
        OP_ABORT  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        KIND_ACK        = 3'd0,
        KIND_TX         = 3'd1,
        KIND_FRAME      = 3'd2,
        KIND_REJECT     = 3'd3,
        KIND_NONE_READY = 3'd4,
        KIND_NONE_SEND  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_FRAME     = 2'd1,
        EV_NO_MARKER = 2'd2,
        EV_TIMEOUT   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TX    = 3'd1,
        PH_GUARD = 3'd2,
        PH_ARMED = 3'd3,
        PH_RX    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TX_DATA,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_TAKE
    } t_state;

endpackage

[rtl/padded_frame_exchange_link_top.sv]
// top level: half-duplex request/response link controller
//
// Each transaction is taken into a holding register and executed from there while the result
// register is free; a simple op (load, tick, abort, slot free on a pad byte) is answered from
// that step. A slot free that sends a stored request byte adds a transmit memory read. The
// received byte that completes a response starts the marker search, a receive memory read then
// a compare for each offset, over at most the search window of offsets. A take streams
// FRAME_BYTES results, one per cycle from reads of the receive memory, as fast as the result
// side takes them. Both byte stores are synchronous memories with no reset and no clearing pass;
// the request frame and the response are always written in full before they are read.
module padded_frame_exchange_link_top #(
    parameter int FRAME_BYTES  = pfxl_pkg::FRAME_BYTES_DEF,
    parameter int PAD_BYTES    = pfxl_pkg::PAD_BYTES_DEF,
    parameter int ALIGN_WINDOW = pfxl_pkg::ALIGN_WINDOW_DEF,
    parameter int RX_BYTES     = pfxl_pkg::RX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_op,
    input  logic [7:0]                      i_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_kind,
    output logic [7:0]                      o_byte_out,
    output logic                            o_last_of_run,
    output logic                            o_busy_res,
    output logic                            o_ready_res,
    output logic [1:0]                      o_event_res,
    input  logic                            i_cfg_we,
    input  logic [pfxl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfxl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfxl_pkg::*;

    localparam int TX_TOTAL = FRAME_BYTES + 2 * PAD_BYTES;
    localparam int SPAN     = (RX_BYTES >= FRAME_BYTES) ? RX_BYTES - FRAME_BYTES + 1 : 0;
    localparam int SRCH_LIM = (ALIGN_WINDOW < SPAN) ? ALIGN_WINDOW : SPAN;
    localparam int LD_W     = $clog2(FRAME_BYTES + 1);
    localparam int TX_AW    = $clog2(FRAME_BYTES);
    localparam int TXP_W    = $clog2(TX_TOTAL + 1);
    localparam int RX_AW    = $clog2(RX_BYTES);
    localparam int RXC_W    = $clog2(RX_BYTES + 1);
    localparam int OFF_W    = $clog2(ALIGN_WINDOW + 1);
    localparam int TK_W     = $clog2(FRAME_BYTES);

    t_cfg r_cfg;

    pfxl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (r_cfg)
    );

    t_state           r_state,        n_state;
    t_phase           r_phase,        n_phase;
    logic [2:0]       r_op;
    logic [7:0]       r_data;
    logic [LD_W-1:0]  r_load_count,   n_load_count;
    logic [TXP_W-1:0] r_tx_pos,       n_tx_pos;
    logic [RXC_W-1:0] r_rx_count,     n_rx_count;
    logic [15:0]      r_tick,         n_tick;
    logic [OFF_W-1:0] r_frame_offset, n_frame_offset;
    logic             r_frame_waiting, n_frame_waiting;
    logic [OFF_W-1:0] r_srch_off,     n_srch_off;
    logic [TK_W-1:0]  r_take_idx,     n_take_idx;

    // byte stores and their registered read data
    logic [7:0]       r_tx_mem [FRAME_BYTES];
    logic [7:0]       r_rx_mem [RX_BYTES];
    logic [7:0]       r_tx_rdata;
    logic [7:0]       r_rx_rdata;
    logic             tx_we, tx_re, rx_we, rx_re;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;

    // result register
    logic             r_out_valid;
    logic [2:0]       r_kind;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_busy;
    logic             r_rdy;
    logic [1:0]       r_event;

    logic             out_free;
    logic             emit;
    t_kind            e_kind;
    logic [7:0]       e_byte;
    logic             e_last;
    t_event           e_event;
    logic [15:0]      tick_inc;
    logic             in_frame;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign tick_inc   = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
    assign in_frame   = (r_tx_pos >= TXP_W'(PAD_BYTES)) &&
                        (r_tx_pos < TXP_W'(PAD_BYTES + FRAME_BYTES));

    always_comb begin
        n_state         = r_state;
        n_phase         = r_phase;
        n_load_count    = r_load_count;
        n_tx_pos        = r_tx_pos;
        n_rx_count      = r_rx_count;
        n_tick          = r_tick;
        n_frame_offset  = r_frame_offset;
        n_frame_waiting = r_frame_waiting;
        n_srch_off      = r_srch_off;
        n_take_idx      = r_take_idx;
        tx_we           = 1'b0;
        tx_waddr        = r_load_count[TX_AW-1:0];
        tx_re           = 1'b0;
        tx_raddr        = TX_AW'(r_tx_pos - TXP_W'(PAD_BYTES));
        rx_we           = 1'b0;
        rx_waddr        = r_rx_count[RX_AW-1:0];
        rx_re           = 1'b0;
        rx_raddr        = RX_AW'(r_srch_off);
        emit            = 1'b0;
        e_kind          = KIND_ACK;
        e_byte          = 8'd0;
        e_last          = 1'b1;
        e_event         = EV_NONE;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    emit    = 1'b1;
                    case (r_op)
                        OP_LOAD: begin
                            if (r_phase != PH_IDLE) begin
                                e_kind = KIND_REJECT;
                            end else begin
                                tx_we = 1'b1;
                                if (r_load_count == LD_W'(FRAME_BYTES - 1)) begin
                                    n_load_count    = '0;
                                    n_tx_pos        = '0;
                                    n_frame_waiting = 1'b0;
                                    n_phase         = PH_TX;
                                end else begin
                                    n_load_count = r_load_count + 1'b1;
                                end
                            end
                        end
                        OP_SLOT: begin
                            if (r_phase != PH_TX) begin
                                e_kind = KIND_NONE_SEND;
                            end else begin
                                n_tx_pos = r_tx_pos + 1'b1;
                                if (r_tx_pos == TXP_W'(TX_TOTAL - 1)) begin
                                    n_phase = PH_GUARD;
                                    n_tick  = '0;
                                end
                                if (in_frame) begin
                                    // request byte comes from the store next cycle
                                    tx_re   = 1'b1;
                                    emit    = 1'b0;
                                    n_state = ST_TX_DATA;
                                end else begin
                                    e_kind = KIND_TX;
                                    e_byte = r_cfg.pad_value;
                                end
                            end
                        end
                        OP_RXBYTE: begin
                            if (r_phase == PH_ARMED || r_phase == PH_RX) begin
                                if (r_phase == PH_ARMED) begin
                                    n_phase = PH_RX;
                                    n_tick  = '0;
                                end
                                rx_we      = 1'b1;
                                n_rx_count = r_rx_count + 1'b1;
                                if (r_rx_count == RXC_W'(RX_BYTES - 1)) begin
                                    n_phase = PH_IDLE;
                                    if (SRCH_LIM == 0) begin
                                        e_event = EV_NO_MARKER;
                                    end else begin
                                        emit       = 1'b0;
                                        n_srch_off = '0;
                                        n_state    = ST_SRCH_RD;
                                    end
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_phase == PH_GUARD) begin
                                if (tick_inc >= r_cfg.guard_ticks) begin
                                    n_rx_count = '0;
                                    n_tick     = '0;
                                    n_phase    = PH_ARMED;
                                end else begin
                                    n_tick = tick_inc;
                                end
                            end else if (r_phase == PH_RX) begin
                                if (tick_inc >= r_cfg.timeout_ticks) begin
                                    n_phase = PH_IDLE;
                                    n_tick  = '0;
                                    e_event = EV_TIMEOUT;
                                end else begin
                                    n_tick = tick_inc;
                                end
                            end
                        end
                        OP_TAKE: begin
                            if (!r_frame_waiting) begin
                                e_kind = KIND_NONE_READY;
                            end else begin
                                n_frame_waiting = 1'b0;
                                n_take_idx      = '0;
                                rx_re           = 1'b1;
                                rx_raddr        = RX_AW'(r_frame_offset);
                                emit            = 1'b0;
                                n_state         = ST_TAKE;
                            end
                        end
                        OP_ABORT: begin
                            n_phase         = PH_IDLE;
                            n_frame_waiting = 1'b0;
                            n_load_count    = '0;
                            n_tick          = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TX_DATA: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_TX;
                    e_byte  = r_tx_rdata;
                    n_state = ST_IDLE;
                end
            end
            ST_SRCH_RD: begin
                rx_re   = 1'b1;
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (out_free) begin
                    if (r_rx_rdata == r_cfg.start_marker) begin
                        n_frame_offset  = r_srch_off;
                        n_frame_waiting = 1'b1;
                        emit            = 1'b1;
                        e_event         = EV_FRAME;
                        n_state         = ST_IDLE;
                    end else if (r_srch_off == OFF_W'(SRCH_LIM - 1)) begin
                        emit    = 1'b1;
                        e_event = EV_NO_MARKER;
                        n_state = ST_IDLE;
                    end else begin
                        n_srch_off = r_srch_off + 1'b1;
                        n_state    = ST_SRCH_RD;
                    end
                end
            end
            ST_TAKE: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_FRAME;
                    e_byte = r_rx_rdata;
                    e_last = (r_take_idx == TK_W'(FRAME_BYTES - 1));
                    if (e_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // fetch the next byte as this one moves to the result register
                        n_take_idx = r_take_idx + 1'b1;
                        rx_re      = 1'b1;
                        rx_raddr   = RX_AW'(r_frame_offset) + RX_AW'(n_take_idx);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[tx_waddr] <= r_data;
        end
        if (tx_re) begin
            r_tx_rdata <= r_tx_mem[tx_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_waddr] <= r_data;
        end
        if (rx_re) begin
            r_rx_rdata <= r_rx_mem[rx_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_phase         <= PH_IDLE;
            r_load_count    <= '0;
            r_tx_pos        <= '0;
            r_rx_count      <= '0;
            r_tick          <= '0;
            r_frame_offset  <= '0;
            r_frame_waiting <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_phase         <= n_phase;
            r_load_count    <= n_load_count;
            r_tx_pos        <= n_tx_pos;
            r_rx_count      <= n_rx_count;
            r_tick          <= n_tick;
            r_frame_offset  <= n_frame_offset;
            r_frame_waiting <= n_frame_waiting;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_srch_off <= n_srch_off;
        r_take_idx <= n_take_idx;
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_data <= i_data;
        end
        if (emit) begin
            r_kind  <= e_kind;
            r_byte  <= e_byte;
            r_last  <= e_last;
            r_busy  <= (n_phase != PH_IDLE);
            r_rdy   <= n_frame_waiting;
            r_event <= e_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_byte_out    = r_byte;
    assign o_last_of_run = r_last;
    assign o_busy_res    = r_busy;
    assign o_ready_res   = r_rdy;
    assign o_event_res   = r_event;

    a_ready_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_waiting |-> r_phase == PH_IDLE)
        else $error("frame marked ready while an exchange is active");

    a_rx_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RX |-> (r_rx_count != '0) && (r_rx_count < RXC_W'(RX_BYTES)))
        else $error("receive phase with an impossible byte count");

    a_frame_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_FRAME) |-> (o_event_res == EV_NONE) && !o_ready_res)
        else $error("frame byte result carries an event or a ready flag");

    a_take_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TAKE |-> !r_frame_waiting && (r_phase == PH_IDLE))
        else $error("frame still marked waiting while it streams out");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count < LD_W'(FRAME_BYTES))
        else $error("load count ran past the frame");

endmodule

[rtl/pfxl_cfg_regs.sv]
// configuration register file with reset defaults
module pfxl_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfxl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfxl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pfxl_pkg::t_cfg                  o_cfg
);
    import pfxl_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER:  n_cfg.start_marker  = i_cfg_data[7:0];
                CFG_GUARD_TICKS:   n_cfg.guard_ticks   = i_cfg_data;
                CFG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg_data;
                CFG_PAD_VALUE:     n_cfg.pad_value     = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[tb/sv/padded_frame_exchange_link_top_test.sv]
// self-checking testbench for the padded frame exchange link controller
module padded_frame_exchange_link_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pfxl_pkg::*;

    localparam int FRAME_N        = FRAME_BYTES_DEF;
    localparam int PAD_N          = PAD_BYTES_DEF;
    localparam int RX_N           = RX_BYTES_DEF;
    localparam int TX_TOTAL       = FRAME_N + 2 * PAD_N;
    localparam int SEARCH_N       = (ALIGN_WINDOW_DEF < RX_N - FRAME_N + 1) ?
                                    ALIGN_WINDOW_DEF : RX_N - FRAME_N + 1;
    localparam int RANDOM_ITEMS   = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int END_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // undefined op codes, answered with a plain ack
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // where the start marker sits in a generated response
    localparam int MARK_RANDOM = -2;
    localparam int MARK_NONE   = -1;
    localparam int ABORT_NEVER = -1;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_out;
        logic       last_run;
        logic       busy;
        logic       ready;
        t_event     evt;
    } t_link_result;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [2:0]            i_op       = '0;
    logic [7:0]            i_data     = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [2:0]            o_kind;
    logic [7:0]            o_byte_out;
    logic                  o_last_of_run;
    logic                  o_busy_res;
    logic                  o_ready_res;
    logic [1:0]            o_event_res;

    padded_frame_exchange_link_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_data        (i_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_byte_out    (o_byte_out),
        .o_last_of_run (o_last_of_run),
        .o_busy_res    (o_busy_res),
        .o_ready_res   (o_ready_res),
        .o_event_res   (o_event_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predicted link state
    t_cfg        link_cfg   = CFG_RESET;
    t_phase      link_phase = PH_IDLE;
    int          load_cnt   = 0;
    logic [7:0]  req_bytes [FRAME_N];
    int          tx_pos     = 0;
    logic [7:0]  resp_bytes [RX_N];
    int          rx_cnt     = 0;
    logic [15:0] tick_cnt   = '0;
    int          frame_off  = 0;
    bit          frame_held = 1'b0;

    t_link_result pending_results [$];
    int           mismatch_count = 0;
    int           checked_count  = 0;
    int           sent_count     = 0;
    int           quiet_cycles   = 0;
    int           stall_left     = 0;
    bit           bursts_on      = 1'b1;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit tick_reached(input logic [15:0] limit);
        if (tick_cnt < 16'hFFFF) tick_cnt++;
        return tick_cnt >= limit;
    endfunction

    function automatic void predict_link_results(input logic [2:0] op, input logic [7:0] data);
        t_link_result run_q [$];
        t_link_result r;
        r = '{kind: KIND_ACK, byte_out: 8'h00, last_run: 1'b0, busy: 1'b0, ready: 1'b0,
              evt: EV_NONE};
        case (op)
            OP_LOAD: begin
                if (link_phase != PH_IDLE) begin
                    r.kind = KIND_REJECT;
                end else begin
                    req_bytes[load_cnt] = data;
                    load_cnt++;
                    if (load_cnt >= FRAME_N) begin
                        load_cnt   = 0;
                        tx_pos     = 0;
                        frame_held = 1'b0;
                        link_phase = PH_TX;
                    end
                end
                run_q.push_back(r);
            end
            OP_SLOT: begin
                if (link_phase != PH_TX) begin
                    r.kind = KIND_NONE_SEND;
                end else begin
                    r.kind     = KIND_TX;
                    r.byte_out = (tx_pos >= PAD_N && tx_pos < PAD_N + FRAME_N) ?
                                 req_bytes[tx_pos - PAD_N] : link_cfg.pad_value;
                    tx_pos++;
                    if (tx_pos >= TX_TOTAL) begin
                        link_phase = PH_GUARD;
                        tick_cnt   = '0;
                    end
                end
                run_q.push_back(r);
            end
            OP_RXBYTE: begin
                if (link_phase == PH_ARMED || link_phase == PH_RX) begin
                    if (link_phase == PH_ARMED) begin
                        link_phase = PH_RX;
                        tick_cnt   = '0;
                    end
                    resp_bytes[rx_cnt] = data;
                    rx_cnt++;
                    if (rx_cnt >= RX_N) begin
                        // first matching offset wins
                        link_phase = PH_IDLE;
                        r.evt      = EV_NO_MARKER;
                        for (int off = 0; off < SEARCH_N && r.evt != EV_FRAME; off++) begin
                            if (resp_bytes[off] == link_cfg.start_marker) begin
                                frame_off  = off;
                                frame_held = 1'b1;
                                r.evt      = EV_FRAME;
                            end
                        end
                    end
                end
                run_q.push_back(r);
            end
            OP_TICK: begin
                if (link_phase == PH_GUARD) begin
                    if (tick_reached(link_cfg.guard_ticks)) begin
                        rx_cnt     = 0;
                        tick_cnt   = '0;
                        link_phase = PH_ARMED;
                    end
                end else if (link_phase == PH_RX) begin
                    if (tick_reached(link_cfg.timeout_ticks)) begin
                        link_phase = PH_IDLE;
                        tick_cnt   = '0;
                        r.evt      = EV_TIMEOUT;
                    end
                end
                run_q.push_back(r);
            end
            OP_TAKE: begin
                if (!frame_held) begin
                    r.kind = KIND_NONE_READY;
                    run_q.push_back(r);
                end else begin
                    r.kind = KIND_FRAME;
                    for (int k = 0; k < FRAME_N; k++) begin
                        r.byte_out = resp_bytes[frame_off + k];
                        run_q.push_back(r);
                    end
                    frame_held = 1'b0;
                end
            end
            OP_ABORT: begin
                link_phase = PH_IDLE;
                frame_held = 1'b0;
                load_cnt   = 0;
                tick_cnt   = '0;
                run_q.push_back(r);
            end
            default: run_q.push_back(r);
        endcase
        foreach (run_q[k]) begin
            run_q[k].last_run = (k == run_q.size() - 1);
            run_q[k].busy     = (link_phase != PH_IDLE);
            run_q[k].ready    = frame_held;
            pending_results.push_back(run_q[k]);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on result %0d, %s: got %h, want %h", checked_count, what, got,
                 want);
        mismatch_count++;
    endtask

    // result side: check, stall in bursts, watchdog
    always @(posedge i_clk) begin : result_side
        t_link_result want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("no transaction expected", 8'(o_kind), 8'h00);
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch("kind", 8'(o_kind), 8'(want.kind));
                    if (o_byte_out !== want.byte_out)
                        report_mismatch("byte_out", o_byte_out, want.byte_out);
                    if (o_last_of_run !== want.last_run)
                        report_mismatch("last_of_run", 8'(o_last_of_run), 8'(want.last_run));
                    if (o_busy_res !== want.busy)
                        report_mismatch("busy", 8'(o_busy_res), 8'(want.busy));
                    if (o_ready_res !== want.ready)
                        report_mismatch("ready", 8'(o_ready_res), 8'(want.ready));
                    if (o_event_res !== want.evt)
                        report_mismatch("event", 8'(o_event_res), 8'(want.evt));
                end
                checked_count++;
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) || i_cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left  <= 0;
            i_out_ready <= 1'b1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(1, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid is left high after a transaction so back-to-back items need no toggle
    task automatic send_item(input logic [2:0] op, input logic [7:0] data);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_data     <= data;
        predict_link_results(op, data);
        sent_count++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_link_settings(input logic [7:0] marker, input logic [15:0] guard,
                                       input logic [15:0] tmo, input logic [7:0] pad);
        wait_results_drained();
        if (link_phase != PH_IDLE) begin
            send_item(OP_ABORT, rand_byte());
            wait_results_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_MARKER;
        i_cfg_data <= {8'h00, marker};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GUARD_TICKS;
        i_cfg_data <= guard;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIMEOUT_TICKS;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PAD_VALUE;
        i_cfg_data <= {8'h00, pad};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        link_cfg.start_marker  = marker;
        link_cfg.guard_ticks   = guard;
        link_cfg.timeout_ticks = tmo;
        link_cfg.pad_value     = pad;
    endtask

    // an op that leaves the current phase where it is
    function automatic logic [2:0] noise_op();
        logic [2:0] op;
        do begin
            op = 3'($urandom_range(0, 7));
        end while (op == OP_ABORT ||
                   (link_phase == PH_IDLE && op == OP_LOAD) ||
                   (link_phase == PH_TX && op == OP_SLOT) ||
                   (link_phase == PH_GUARD && op == OP_TICK) ||
                   ((link_phase == PH_ARMED || link_phase == PH_RX) &&
                    (op == OP_RXBYTE || op == OP_TICK)));
        return op;
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] v);
        logic [7:0] b;
        do b = rand_byte(); while (b == v);
        return b;
    endfunction

    task automatic disturb(input bit noisy, input int abort_stage, output bit cut);
        cut = 1'b0;
        if (noisy && $urandom_range(0, 9) == 0) send_item(noise_op(), rand_byte());
        if (abort_stage == int'(link_phase) && $urandom_range(0, 7) == 0) begin
            send_item(OP_ABORT, rand_byte());
            cut = 1'b1;
        end
    endtask

    // one request/response exchange driven from the predicted phase
    task automatic run_exchange(input int marker_at, input bit cut_short, input int abort_stage,
                                input bit noisy);
        logic [7:0] resp [RX_N];
        int         n_rx;
        int         i;
        bit         cut;
        if (link_phase != PH_IDLE) send_item(OP_ABORT, rand_byte());
        while (link_phase == PH_IDLE) begin
            disturb(noisy, abort_stage, cut);
            if (cut) return;
            send_item(OP_LOAD, rand_byte());
        end
        while (link_phase == PH_TX) begin
            disturb(noisy, abort_stage, cut);
            if (cut) return;
            send_item(OP_SLOT, rand_byte());
        end
        while (link_phase == PH_GUARD) begin
            disturb(noisy, abort_stage, cut);
            if (cut) return;
            send_item(OP_TICK, rand_byte());
        end
        for (i = 0; i < RX_N; i++) resp[i] = rand_byte();
        if (marker_at == MARK_NONE) begin
            for (i = 0; i < SEARCH_N; i++) resp[i] = byte_other_than(link_cfg.start_marker);
        end else if (marker_at >= 0) begin
            for (i = 0; i < marker_at; i++) resp[i] = byte_other_than(link_cfg.start_marker);
            resp[marker_at] = link_cfg.start_marker;
        end
        n_rx = cut_short ? $urandom_range(1, RX_N - 1) : RX_N;
        i    = 0;
        while ((link_phase == PH_ARMED || link_phase == PH_RX) && i < n_rx) begin
            disturb(noisy, abort_stage, cut);
            if (cut) return;
            // ticks that stay short of the timeout
            if (noisy && link_phase == PH_RX && tick_cnt + 1 < link_cfg.timeout_ticks &&
                $urandom_range(0, 7) == 0)
                send_item(OP_TICK, rand_byte());
            send_item(OP_RXBYTE, resp[i]);
            i++;
        end
        while (link_phase == PH_RX) send_item(OP_TICK, rand_byte());
        if (frame_held) begin
            if ($urandom_range(0, 3) == 0) wait_results_drained();
            send_item(OP_TAKE, rand_byte());
            if ($urandom_range(0, 2) == 0) send_item(OP_TAKE, rand_byte());
        end
    endtask

    task automatic test_idle_ops();
        send_item(OP_TAKE, 8'h00);
        send_item(OP_SLOT, 8'hFF);
        send_item(OP_RXBYTE, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_SPARE_6, 8'hFF);
        send_item(OP_SPARE_7, 8'h00);
        send_item(OP_LOAD, 8'h00);
        send_item(OP_LOAD, 8'hFF);
        send_item(OP_ABORT, 8'h00);
        send_item(OP_LOAD, 8'hA5);
        send_item(OP_ABORT, 8'hFF);
    endtask

    task automatic test_reset_settings_exchange();
        run_exchange(0, 1'b0, ABORT_NEVER, 1'b1);
    endtask

    task automatic test_marker_window();
        apply_link_settings(8'hFF, 16'd0, 16'hFFFF, 8'h00);
        for (int m = 1; m < SEARCH_N; m++) run_exchange(m, 1'b0, ABORT_NEVER, 1'b1);
        run_exchange(MARK_NONE, 1'b0, ABORT_NEVER, 1'b1);
        send_item(OP_TAKE, 8'h3C);
    endtask

    task automatic test_rx_timeout();
        apply_link_settings(rand_byte(), 16'd2, 16'd0, 8'hA5);
        run_exchange(MARK_RANDOM, 1'b1, ABORT_NEVER, 1'b1);
        apply_link_settings(rand_byte(), 16'd1, 16'd3, 8'h5A);
        run_exchange(MARK_RANDOM, 1'b1, ABORT_NEVER, 1'b1);
    endtask

    task automatic test_long_intervals();
        apply_link_settings(8'h5A, 16'hFFFF, 16'hFFFF, 8'hFF);
        run_exchange(MARK_RANDOM, 1'b0, int'(PH_GUARD), 1'b1);
        apply_link_settings(8'h5A, 16'd0, 16'hFFFF, 8'hFF);
        run_exchange(MARK_RANDOM, 1'b0, int'(PH_RX), 1'b1);
    endtask

    task automatic test_random_traffic();
        int          first;
        logic [7:0]  marker;
        logic [15:0] tmo;
        first = sent_count;
        while (sent_count - first < RANDOM_ITEMS) begin
            bursts_on = ($urandom_range(0, 9) < 7);
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0: marker = 8'h00;
                        1: marker = 8'hFF;
                        default: marker = rand_byte();
                    endcase
                    tmo = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4)) :
                          16'($urandom_range(1000, 65535));
                    apply_link_settings(marker, 16'($urandom_range(0, 6)), tmo,
                                        rand_byte());
                end
                1, 2: begin
                    // unstructured traffic, aborts included
                    repeat ($urandom_range(3, 15))
                        send_item(3'($urandom_range(0, 7)), rand_byte());
                end
                default: begin
                    run_exchange($urandom_range(0, SEARCH_N + 1) - 2,
                                 link_cfg.timeout_ticks <= 8 && $urandom_range(0, 3) == 0,
                                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) :
                                 ABORT_NEVER,
                                 1'b1);
                end
            endcase
        end
    endtask

    task automatic test_quiet_finish();
        bursts_on = 1'b0;
        apply_link_settings(rand_byte(), 16'($urandom_range(0, 6)),
                            16'($urandom_range(1000, 65535)), rand_byte());
        run_exchange($urandom_range(0, SEARCH_N - 1), 1'b0, ABORT_NEVER, 1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ops();
        test_reset_settings_exchange();
        test_marker_window();
        test_rx_timeout();
        test_long_intervals();
        test_random_traffic();
        test_quiet_finish();
        wait_results_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pfxl_pkg.sv
rtl/pfxl_cfg_regs.sv
rtl/padded_frame_exchange_link_top.sv
tb/sv/padded_frame_exchange_link_top_test.sv
